// ===== src/spwd_pkg.sv =====
// shared constants and types for the sbus pulse-width deframer
package spwd_pkg;

	localparam int IN_W            = 16;
	localparam int QW              = IN_W + 1;
	localparam int SLOT_BITS       = 12;
	localparam int HIGH_LIMIT      = 10;
	localparam int FRAME_CHARS_DEF = 25;
	localparam int BIT_TIME_US_DEF = 10;

	localparam logic [SLOT_BITS-1:0] SLOT_MASK  = 12'hFFF;
	localparam logic [SLOT_BITS-1:0] STOP_MASK  = 12'hC00;
	localparam logic [SLOT_BITS-1:0] PARITY_BIT = 12'h200;
	localparam logic [7:0]           DATA_MASK  = 8'hFF;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== src/sbus_pulse_width_deframer_top.sv =====
// top level of the sbus pulse-width deframer: sequencer, frame check and output register
//
// s_* channel: one transfer per captured pulse pair, tdata = {low_width_us, high_width_us}.
// Each width is turned into a bit count by a shared reciprocal-multiply divider, then
// the high bits are merged into the current 12-bit character slot with one
// read-modify-write of the slot memory. An ordinary pulse pair passes through the
// hi divide, lo divide, slot read and slot write states, with s_tready low until idle.
// When the last slot is complete and a long low run follows, the sequencer walks all
// FRAME_CHARS slots twice: once to check start, stop and even parity, reading each
// slot before checking it, then to send the data bytes, each read and then loaded
// into the output register once it is free. The first byte follows the whole check walk.
// m_* channel: one transfer per data byte, tlast on the final byte of the frame.
// A frame that fails any check sends nothing. A stall on m_* holds the sequencer in
// the send walk; the last byte sits in the output register while new pulses are taken.
// Reset clears the bit offset and marks every slot empty at once, no clearing pass.
module sbus_pulse_width_deframer_top
	import spwd_pkg::*;
#(
	parameter int FRAME_CHARS = FRAME_CHARS_DEF,
	parameter int BIT_TIME_US = BIT_TIME_US_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] high_width_us, [31:16] low_width_us
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] frame_byte
	output logic        m_tlast   // last_byte
);

	localparam int AW = FRAME_CHARS > 1 ? $clog2(FRAME_CHARS) : 1;
	localparam int SW = $clog2(FRAME_CHARS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV_HI, S_DIV_LO, S_UPD_RD, S_UPD_WR,
		S_CHK_RD, S_CHK_EV, S_EM_RD, S_EM_EV
	} state_t;

	state_t            state_q;
	logic [IN_W-1:0]   lo_w_q;
	logic [QW-1:0]     hi_q;
	logic [QW-1:0]     lo_q;
	logic [SW-1:0]     slot_q;
	logic [3:0]        pos_q;
	logic [AW-1:0]     idx_q;
	logic              m_tvalid_q;
	logic [7:0]        m_data_q;
	logic              m_last_q;

	logic              s_xfer;
	logic              div_start;
	logic [QW-1:0]     div_dividend;
	div_stat_t         div_stat;
	logic [QW-1:0]     quotient;

	logic              clr;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [SLOT_BITS-1:0] rd_data;
	logic              wr_en;
	logic [SLOT_BITS-1:0] wr_data;

	logic              upd_bad;
	logic [3:0]        p1;
	logic [3:0]        room;
	logic              lo_fits;
	logic [3:0]        np;
	logic              brk;
	logic              frame_end;
	logic [SLOT_BITS-1:0] mask;
	logic [SLOT_BITS-1:0] v;
	logic              slot_ok;
	logic              out_free;
	logic              idx_last;

	assign s_tready = state_q == S_IDLE;
	assign s_xfer   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign idx_last = idx_q == AW'(FRAME_CHARS - 1);

	// hi divide starts on the transfer, lo divide right when hi is done
	assign div_start    = s_xfer || (state_q == S_DIV_HI && div_stat.done);
	assign div_dividend = s_xfer ? ({1'b0, s_tdata[15:0]} + QW'(1))
	                             : ({1'b0, lo_w_q} + QW'(1));

	spwd_div #(
		.BIT_TIME_US(BIT_TIME_US)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.stat     (div_stat),
		.quotient (quotient)
	);

	spwd_store #(
		.FRAME_CHARS(FRAME_CHARS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (clr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (slot_q[AW-1:0]),
		.wr_data (wr_data)
	);

	always_comb begin
		// high run must end at or before the parity bit, clear of the stop bits of the slot
		upd_bad = (hi_q == '0) || (lo_q == '0) ||
		          (({1'b0, hi_q} + (QW + 1)'(pos_q)) > (QW + 1)'(HIGH_LIMIT)) ||
		          (slot_q == SW'(FRAME_CHARS));
		p1      = pos_q + hi_q[3:0];
		room    = 4'(SLOT_BITS) - p1;
		lo_fits = lo_q <= QW'(room);
		np      = lo_fits ? (p1 + lo_q[3:0]) : 4'(SLOT_BITS);
		// leftover low bits beyond the slot end exceed one character
		brk       = lo_q > (QW'(2 * SLOT_BITS) - QW'(p1));
		frame_end = brk && ((slot_q + 1'b1) == SW'(FRAME_CHARS));
		for (int b = 0; b < SLOT_BITS; b++)
			mask[b] = (4'(b) >= pos_q) && (4'(b) < p1);
		wr_data = (rd_data | mask) & SLOT_MASK;
		v       = ~rd_data & SLOT_MASK;
		slot_ok = !v[0] && ((v & STOP_MASK) == STOP_MASK) && ((^v[8:1]) == v[9]);
		rd_en   = state_q == S_UPD_RD || state_q == S_CHK_RD || state_q == S_EM_RD;
		rd_addr = (state_q == S_UPD_RD) ? slot_q[AW-1:0] : idx_q;
		wr_en   = state_q == S_UPD_WR;
		unique case (state_q)
			S_UPD_RD: clr = upd_bad;
			S_UPD_WR: clr = brk && !frame_end;
			S_CHK_EV: clr = !slot_ok;
			S_EM_EV:  clr = out_free && idx_last;
			default:  clr = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			slot_q     <= '0;
			pos_q      <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_xfer)
						state_q <= S_DIV_HI;
				end
				S_DIV_HI: begin
					if (div_stat.done)
						state_q <= S_DIV_LO;
				end
				S_DIV_LO: begin
					if (div_stat.done)
						state_q <= S_UPD_RD;
				end
				S_UPD_RD: begin
					state_q <= upd_bad ? S_IDLE : S_UPD_WR;
				end
				S_UPD_WR: begin
					if (np == 4'(SLOT_BITS)) begin
						slot_q <= slot_q + 1'b1;
						pos_q  <= '0;
					end else begin
						pos_q <= np;
					end
					idx_q   <= '0;
					state_q <= frame_end ? S_CHK_RD : S_IDLE;
				end
				S_CHK_RD: begin
					state_q <= S_CHK_EV;
				end
				S_CHK_EV: begin
					if (!slot_ok) begin
						state_q <= S_IDLE;
					end else if (idx_last) begin
						idx_q   <= '0;
						state_q <= S_EM_RD;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_CHK_RD;
					end
				end
				S_EM_RD: begin
					state_q <= S_EM_EV;
				end
				S_EM_EV: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (idx_last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_EM_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (clr) begin
				slot_q <= '0;
				pos_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer)
			lo_w_q <= s_tdata[31:16];
		if (state_q == S_DIV_HI && div_stat.done)
			hi_q <= quotient;
		if (state_q == S_DIV_LO && div_stat.done)
			lo_q <= quotient;
		if (state_q == S_EM_EV && out_free) begin
			m_data_q <= v[8:1] & DATA_MASK;
			m_last_q <= idx_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== src/spwd_div.sv =====
// shared divider by the constant bit time: reciprocal multiply, dividend and product registered
module spwd_div
	import spwd_pkg::*;
#(
	parameter int BIT_TIME_US = BIT_TIME_US_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [QW-1:0] dividend,
	output div_stat_t     stat,
	output logic [QW-1:0] quotient
);

	localparam int RL = $clog2(BIT_TIME_US);
	localparam int SH = QW + RL;
	localparam int MW = QW + 2;
	localparam int PW = QW + MW;
	// ceil(2^SH / BIT_TIME_US) is exact for every QW-bit dividend
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << SH) + 64'(BIT_TIME_US) - 64'd1) / 64'(BIT_TIME_US));

	logic          busy_q;
	logic          done_q;
	logic [QW-1:0] x_q;
	logic [PW-1:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			x_q <= dividend;
		if (busy_q)
			prod_q <= PW'(x_q) * PW'(RECIP);
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = QW'(prod_q >> SH);

endmodule

// ===== src/spwd_store.sv =====
// character slot memory with per-slot valid bits, registered read
module spwd_store
	import spwd_pkg::*;
#(
	parameter int FRAME_CHARS = FRAME_CHARS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   clr,
	input  logic                                   rd_en,
	input  logic [(FRAME_CHARS>1 ? $clog2(FRAME_CHARS) : 1)-1:0] rd_addr,
	output logic [SLOT_BITS-1:0]                   rd_data,
	input  logic                                   wr_en,
	input  logic [(FRAME_CHARS>1 ? $clog2(FRAME_CHARS) : 1)-1:0] wr_addr,
	input  logic [SLOT_BITS-1:0]                   wr_data
);

	logic [SLOT_BITS-1:0]   mem [FRAME_CHARS];
	logic [FRAME_CHARS-1:0] valid_q;
	logic [SLOT_BITS-1:0]   rd_raw_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (rd_en)
				rd_vld_q <= valid_q[rd_addr];
			if (clr)
				valid_q <= '0;
			else if (wr_en)
				valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_raw_q <= mem[rd_addr];
	end

	// a slot never written since the last clear reads as zero
	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule
